@@ hw/rtl/tre_pkg.sv @@
// Shared types and constants for the tail rate estimator.
package tre_pkg;

	localparam int CNT_MAX_W = 17;
	localparam int FRAC_W    = 17;
	localparam int RATE_FRAC = 20;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_FEW  = 2'd1;
	localparam logic [1:0] ST_ZERO = 2'd2;
	localparam logic [1:0] ST_OVF  = 2'd3;

	typedef struct packed {
		logic [31:0] interval;
		logic        last;
	} item_t;

	typedef struct packed {
		logic [31:0] rate;
		logic [1:0]  status;
		logic [12:0] tail_count;
	} result_t;

	typedef struct packed {
		logic [CNT_MAX_W-1:0] n;
		logic                 ovf;
	} job_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_SETUP,
		B_CLAMP,
		B_SEL,
		B_SUM,
		B_DIV,
		B_OUT
	} back_state_t;

endpackage

@@ hw/rtl/tre_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module tre_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ hw/rtl/tre_front.sv @@
// Front end: accepts intervals, stores nonzero ones, posts a job on the last one.
module tre_front #(
	parameter int MAX_SAMPLES = 4096,
	parameter int TIME_BITS   = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           accept,
	input  tre_pkg::item_t                 item,
	output logic                           we,
	output logic [$clog2(MAX_SAMPLES)-1:0] waddr,
	output logic [TIME_BITS-1:0]           wdata,
	output logic                           push,
	output tre_pkg::job_t                  job
);

	localparam int AW = $clog2(MAX_SAMPLES);
	localparam int CW = $clog2(MAX_SAMPLES + 1);
	localparam int KB = (TIME_BITS < 32) ? TIME_BITS : 32;

	logic [CW-1:0] cnt_q;
	logic          ovf_q;
	logic [CW-1:0] cnt_nx;
	logic          ovf_nx;
	logic          nz;
	logic          room;

	always_comb begin
		wdata  = TIME_BITS'(item.interval[KB-1:0]);
		nz     = (wdata != '0);
		room   = (cnt_q < CW'(MAX_SAMPLES));
		we     = accept && nz && room;
		waddr  = cnt_q[AW-1:0];
		cnt_nx = we ? cnt_q + CW'(1) : cnt_q;
		ovf_nx = ovf_q | (accept && nz && !room);
		push   = accept && item.last;
		job.n   = tre_pkg::CNT_MAX_W'(cnt_nx);
		job.ovf = ovf_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			ovf_q <= 1'b0;
		end else if (accept) begin
			// close the batch on last
			if (item.last) begin
				cnt_q <= '0;
				ovf_q <= 1'b0;
			end else begin
				cnt_q <= cnt_nx;
				ovf_q <= ovf_nx;
			end
		end
	end

endmodule

@@ hw/rtl/tre_fifo.sv @@
// Two-entry job queue between front and back.
module tre_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  tre_pkg::job_t push_data,
	input  logic          pop,
	output logic          not_empty,
	output tre_pkg::job_t pop_data
);

	tre_pkg::job_t entry_q [2];
	logic          wr_q;
	logic          rd_q;
	logic [1:0]    fill_q;

	assign not_empty = (fill_q != 2'd0);
	assign pop_data  = entry_q[rd_q];

	always_ff @(posedge clk) begin
		if (push && fill_q != 2'd2) begin
			entry_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= 1'b0;
			rd_q   <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (push && fill_q != 2'd2) begin
				wr_q <= ~wr_q;
			end
			if (pop && not_empty) begin
				rd_q <= ~rd_q;
			end
			fill_q <= fill_q + 2'((push && fill_q != 2'd2) ? 1 : 0)
				- 2'((pop && not_empty) ? 1 : 0);
		end
	end

endmodule

@@ hw/rtl/tre_back.sv @@
// Back end: radix selection of the threshold, tail sum, and rate division.
module tre_back #(
	parameter int MAX_SAMPLES = 4096,
	parameter int TIME_BITS   = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [tre_pkg::FRAC_W-1:0]     keep_frac,
	input  logic                           job_valid,
	input  tre_pkg::job_t                  job,
	output logic                           pop,
	output logic                           active,
	output logic [$clog2(MAX_SAMPLES)-1:0] raddr,
	input  logic [TIME_BITS-1:0]           rdata,
	output logic                           done,
	output tre_pkg::result_t               result
);

	localparam int AW  = $clog2(MAX_SAMPLES);
	localparam int CW  = $clog2(MAX_SAMPLES + 1);
	localparam int W   = TIME_BITS;
	localparam int BW  = (W > 1) ? $clog2(W) : 1;
	localparam int SW  = W + CW;
	localparam int DW  = CW + tre_pkg::RATE_FRAC;
	localparam int DCW = $clog2(DW + 1);
	localparam int PW  = CW + tre_pkg::FRAC_W;

	tre_pkg::back_state_t state_q, state_d;

	logic [CW-1:0]    n_q;
	logic             ovf_q;
	logic [CW-1:0]    k_q;
	logic [CW-1:0]    c_q;
	logic [CW-1:0]    cnt_q;
	logic [CW-1:0]    addr_q;
	logic             vld_s1;
	logic [BW-1:0]    bit_q;
	logic [W-1:0]     prefix_q;
	logic [W-1:0]     thr_q;
	logic [SW-1:0]    sum_q;
	logic [SW:0]      rem_q;
	logic [DW-1:0]    dd_q;
	logic [DW-1:0]    quo_q;
	logic [DCW-1:0]   dcnt_q;
	tre_pkg::result_t res_q;

	logic [PW-1:0]    prod;
	logic [CW-1:0]    start_c;
	logic             issue;
	logic             pass_end;
	logic             match;
	logic [W-1:0]     hi_mask;
	logic [W-1:0]     prefix_nx;
	logic [SW:0]      rem2;

	always_comb begin
		prod = PW'(n_q) * PW'(tre_pkg::FRAC_W'(65536) - keep_frac);
		start_c = keep_frac[tre_pkg::FRAC_W-1] ? '0 : prod[CW+15:16];
		issue    = (addr_q < n_q);
		pass_end = !issue && !vld_s1;
		raddr    = addr_q[AW-1:0];
		hi_mask  = ~((W'(1) << bit_q) | ((W'(1) << bit_q) - W'(1)));
		match    = (((rdata ^ prefix_q) & hi_mask) == '0) && !rdata[bit_q];
		prefix_nx = prefix_q;
		if (k_q >= c_q) begin
			prefix_nx[bit_q] = 1'b1;
		end
		rem2 = {rem_q[SW-1:0], dd_q[DW-1]};
	end

	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		unique case (state_q)
			tre_pkg::B_IDLE: begin
				if (job_valid) begin
					pop     = 1'b1;
					state_d = tre_pkg::B_SETUP;
				end
			end
			tre_pkg::B_SETUP: state_d = (n_q < CW'(2)) ? tre_pkg::B_OUT : tre_pkg::B_CLAMP;
			tre_pkg::B_CLAMP: state_d = (k_q == '0 || n_q - CW'(2) == '0)
				? tre_pkg::B_SUM : tre_pkg::B_SEL;
			tre_pkg::B_SEL: begin
				if (pass_end && bit_q == '0) begin
					state_d = tre_pkg::B_SUM;
				end
			end
			tre_pkg::B_SUM: begin
				if (pass_end) begin
					state_d = (sum_q == '0) ? tre_pkg::B_OUT : tre_pkg::B_DIV;
				end
			end
			tre_pkg::B_DIV: begin
				if (dcnt_q == '0) begin
					state_d = tre_pkg::B_OUT;
				end
			end
			tre_pkg::B_OUT: state_d = tre_pkg::B_IDLE;
			default: state_d = tre_pkg::B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tre_pkg::B_IDLE;
			vld_s1  <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1  <= (state_q == tre_pkg::B_SEL || state_q == tre_pkg::B_SUM) && issue;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			tre_pkg::B_IDLE: begin
				n_q   <= CW'(job.n);
				ovf_q <= job.ovf;
			end
			tre_pkg::B_SETUP: begin
				k_q            <= start_c;
				res_q.rate     <= '0;
				res_q.status   <= tre_pkg::ST_FEW;
				res_q.tail_count <= '0;
			end
			tre_pkg::B_CLAMP: begin
				// rank never passes n-2; rank 0 means threshold 0
				if (k_q > n_q - CW'(2)) begin
					k_q   <= n_q - CW'(2);
					cnt_q <= CW'(2);
				end else begin
					cnt_q <= n_q - k_q;
				end
				thr_q    <= '0;
				prefix_q <= '0;
				bit_q    <= BW'(W - 1);
				c_q      <= '0;
				addr_q   <= '0;
				sum_q    <= '0;
			end
			tre_pkg::B_SEL: begin
				if (issue) begin
					addr_q <= addr_q + CW'(1);
				end
				if (vld_s1 && match) begin
					c_q <= c_q + CW'(1);
				end
				if (pass_end) begin
					// fix this bit and move to the next lower one
					prefix_q <= prefix_nx;
					if (k_q >= c_q) begin
						k_q <= k_q - c_q;
					end
					c_q    <= '0;
					addr_q <= '0;
					if (bit_q == '0) begin
						thr_q <= prefix_nx;
					end else begin
						bit_q <= bit_q - BW'(1);
					end
				end
			end
			tre_pkg::B_SUM: begin
				if (issue) begin
					addr_q <= addr_q + CW'(1);
				end
				if (vld_s1 && rdata > thr_q) begin
					sum_q <= sum_q + SW'(rdata - thr_q);
				end
				if (pass_end) begin
					res_q.rate       <= '0;
					res_q.status     <= tre_pkg::ST_ZERO;
					res_q.tail_count <= 13'(cnt_q);
					rem_q  <= '0;
					quo_q  <= '0;
					dd_q   <= {cnt_q, {tre_pkg::RATE_FRAC{1'b0}}};
					dcnt_q <= DCW'(DW);
				end
			end
			tre_pkg::B_DIV: begin
				if (dcnt_q != '0) begin
					dd_q   <= {dd_q[DW-2:0], 1'b0};
					dcnt_q <= dcnt_q - DCW'(1);
					if (rem2 >= (SW+1)'(sum_q)) begin
						rem_q <= rem2 - (SW+1)'(sum_q);
						quo_q <= {quo_q[DW-2:0], 1'b1};
					end else begin
						rem_q <= rem2;
						quo_q <= {quo_q[DW-2:0], 1'b0};
					end
				end else begin
					res_q.rate   <= (quo_q > DW'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : 32'(quo_q);
					res_q.status <= ovf_q ? tre_pkg::ST_OVF : tre_pkg::ST_OK;
				end
			end
			tre_pkg::B_OUT: begin
			end
			default: begin
			end
		endcase
	end

	assign active = (state_q != tre_pkg::B_IDLE);
	assign done   = (state_q == tre_pkg::B_OUT);
	assign result = res_q;

	a_done_then_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> (state_q == tre_pkg::B_IDLE))
		else $error("back did not return to idle after a result");
	a_few_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status == tre_pkg::ST_FEW) |-> (result.rate == '0 && result.tail_count == '0))
		else $error("short batch result carries a rate or count");
	a_rank_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tre_pkg::B_SEL) |-> (k_q < n_q))
		else $error("selection rank out of range");
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tre_pkg::B_DIV) |-> (sum_q != '0))
		else $error("division by a zero tail sum");

endmodule

@@ hw/rtl/tail_rate_estimator_top.sv @@
// Top level of the tail rate estimator.
// Intervals are taken one per cycle while busy is low; each nonzero one is written to the
// sample memory while it has room. The item marked last closes the batch and busy then stays
// high while the back end works: for n stored samples it makes TIME_BITS selection passes
// over the memory (none when the rank is zero), then one summing pass, then a restoring
// divide (skipped on a zero tail sum); each pass reads the samples through the single memory
// read port. A batch with fewer than two samples skips the passes and goes straight to the
// result. The result appears with done for exactly one cycle and must be captured then.
module tail_rate_estimator_top #(
	parameter int MAX_SAMPLES = 4096,
	parameter int TIME_BITS   = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  tre_pkg::item_t                item,
	output logic                          done,
	output tre_pkg::result_t              result,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [tre_pkg::FRAC_W-1:0]    cfg_data
);

	localparam int AW = $clog2(MAX_SAMPLES);

	logic [tre_pkg::FRAC_W-1:0] frac_q;
	logic                       accept;
	logic                       we;
	logic [AW-1:0]              waddr;
	logic [AW-1:0]              raddr;
	logic [TIME_BITS-1:0]       wdata;
	logic [TIME_BITS-1:0]       rdata;
	logic                       push;
	logic                       pop;
	logic                       job_valid;
	logic                       back_active;
	tre_pkg::job_t              push_job;
	tre_pkg::job_t              pop_job;

	assign cfg_ready = 1'b1;
	assign busy      = job_valid || back_active;
	assign accept    = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frac_q <= tre_pkg::FRAC_W'(32768);
		end else if (cfg_valid && cfg_ready) begin
			frac_q <= cfg_data;
		end
	end

	tre_front #(.MAX_SAMPLES(MAX_SAMPLES), .TIME_BITS(TIME_BITS)) u_front (
		.clk(clk), .arst_n(arst_n), .accept(accept), .item(item),
		.we(we), .waddr(waddr), .wdata(wdata), .push(push), .job(push_job)
	);

	tre_ram #(.WIDTH(TIME_BITS), .DEPTH(MAX_SAMPLES)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	tre_fifo u_fifo (
		.clk(clk), .arst_n(arst_n), .push(push), .push_data(push_job),
		.pop(pop), .not_empty(job_valid), .pop_data(pop_job)
	);

	tre_back #(.MAX_SAMPLES(MAX_SAMPLES), .TIME_BITS(TIME_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .keep_frac(frac_q),
		.job_valid(job_valid), .job(pop_job), .pop(pop), .active(back_active),
		.raddr(raddr), .rdata(rdata), .done(done), .result(result)
	);

endmodule
